@@ rtl/belt_tension_mode_controller_macros.svh @@
// Assertion macros shared by the belt tension mode controller RTL.
// Included by files that carry concurrent checks; needs no other file.
`ifndef BELT_TENSION_MODE_CONTROLLER_MACROS_SVH
`define BELT_TENSION_MODE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BTMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/btmc_pkg.sv @@
// Shared types and constants for the belt tension mode controller.
// Used by btmc_cfg_regs, btmc_step and the top level; depends on nothing.
`timescale 1ns / 1ps

package btmc_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int TENSION_W   = 16;
    localparam int LIMIT_W     = 15;
    localparam int STEP_W      = 10;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);

    typedef enum logic [2:0] {
        MODE_READY      = 3'd0,
        MODE_FREEING    = 3'd1,
        MODE_RELEASING  = 3'd2,
        MODE_PARKING    = 3'd3,
        MODE_SLACK      = 3'd4,
        MODE_WARNING    = 3'd5,
        MODE_PRETENSION = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_BUCKLE   = 3'd1,
        CMD_UNBUCKLE = 3'd2,
        CMD_ALERT    = 3'd3,
        CMD_TIGHTEN  = 3'd4,
        CMD_RELEASE  = 3'd5,
        CMD_FREE     = 3'd6,
        CMD_INVALID  = 3'd7
    } t_command;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REF_TABLE_LOW   = 3'd0,
        CFG_REF_TABLE_HIGH  = 3'd1,
        CFG_PARKING_DONE    = 3'd2,
        CFG_SLACK_DONE      = 3'd3,
        CFG_FREEING_LIMIT   = 3'd4,
        CFG_RELEASING_LIMIT = 3'd5,
        CFG_WARNING_LIMIT   = 3'd6,
        CFG_PERIOD_STEP     = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic [63:0]                  ref_table_low;
        logic [47:0]                  ref_table_high;
        logic signed [TENSION_W-1:0]  parking_done_tension;
        logic signed [TENSION_W-1:0]  slack_done_tension;
        logic [LIMIT_W-1:0]           freeing_limit;
        logic [LIMIT_W-1:0]           releasing_limit;
        logic [LIMIT_W-1:0]           warning_limit;
        logic [STEP_W-1:0]            period_step;
    } t_cfg;

    // Register contents after reset: everything zero except the period step.
    localparam t_cfg CFG_RESET = '{
        ref_table_low:        '0,
        ref_table_high:       '0,
        parking_done_tension: '0,
        slack_done_tension:   '0,
        freeing_limit:        '0,
        releasing_limit:      '0,
        warning_limit:        '0,
        period_step:          STEP_RESET
    };

endpackage

@@ rtl/btmc_cfg_regs.sv @@
// Configuration register file of the belt tension mode controller.
// Depends on btmc_pkg for the register index codes and the t_cfg bundle.
`timescale 1ns / 1ps

module btmc_cfg_regs
    import btmc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_REF_TABLE_LOW:   r_cfg.ref_table_low        <= i_cfg_data;
                CFG_REF_TABLE_HIGH:  r_cfg.ref_table_high       <= i_cfg_data[47:0];
                CFG_PARKING_DONE:    r_cfg.parking_done_tension <= i_cfg_data[TENSION_W-1:0];
                CFG_SLACK_DONE:      r_cfg.slack_done_tension   <= i_cfg_data[TENSION_W-1:0];
                CFG_FREEING_LIMIT:   r_cfg.freeing_limit        <= i_cfg_data[LIMIT_W-1:0];
                CFG_RELEASING_LIMIT: r_cfg.releasing_limit      <= i_cfg_data[LIMIT_W-1:0];
                CFG_WARNING_LIMIT:   r_cfg.warning_limit        <= i_cfg_data[LIMIT_W-1:0];
                CFG_PERIOD_STEP:     r_cfg.period_step          <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/btmc_step.sv @@
// Combinational step of the mode controller: reference lookup and transition.
// Depends on btmc_pkg for mode and command codes and the t_cfg bundle.
`timescale 1ns / 1ps

module btmc_step
    import btmc_pkg::*;
#(
    parameter int TIMER_BITS = 15
) (
    input  t_mode                        i_mode,
    input  logic [TIMER_BITS-1:0]        i_timer,
    input  logic [2:0]                   i_command,
    input  logic signed [TENSION_W-1:0]  i_belt_tension,
    input  t_cfg                         i_cfg,
    output logic signed [TENSION_W-1:0]  o_tension_ref,
    output t_mode                        o_mode,
    output logic [TIMER_BITS-1:0]        o_timer
);

    // Compare width covers both the timer and the 15-bit limits.
    localparam int CMP_W = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;
    // Sum width leaves room for one carry above timer or step.
    localparam int SUM_W = ((TIMER_BITS > STEP_W) ? TIMER_BITS : STEP_W) + 1;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    t_command             cmd;
    logic [CMP_W-1:0]     timer_cmp;
    logic [SUM_W-1:0]     timer_sum;
    logic [TIMER_BITS-1:0] timer_adv;
    logic                 freeing_over;
    logic                 releasing_over;
    logic                 warning_over;

    assign cmd       = t_command'(i_command);
    assign timer_cmp = CMP_W'(i_timer);
    assign timer_sum = SUM_W'(i_timer) + SUM_W'(i_cfg.period_step);
    assign timer_adv = (timer_sum > SUM_W'(TIMER_MAX)) ? TIMER_MAX
                                                       : timer_sum[TIMER_BITS-1:0];

    assign freeing_over   = timer_cmp > CMP_W'(i_cfg.freeing_limit);
    assign releasing_over = timer_cmp > CMP_W'(i_cfg.releasing_limit);
    assign warning_over   = timer_cmp > CMP_W'(i_cfg.warning_limit);

    always_comb begin
        case (i_mode)
            MODE_READY:      o_tension_ref = i_cfg.ref_table_low[15:0];
            MODE_FREEING:    o_tension_ref = i_cfg.ref_table_low[31:16];
            MODE_RELEASING:  o_tension_ref = i_cfg.ref_table_low[47:32];
            MODE_PARKING:    o_tension_ref = i_cfg.ref_table_low[63:48];
            MODE_SLACK:      o_tension_ref = i_cfg.ref_table_high[15:0];
            MODE_WARNING:    o_tension_ref = i_cfg.ref_table_high[31:16];
            MODE_PRETENSION: o_tension_ref = i_cfg.ref_table_high[47:32];
            default:         o_tension_ref = '0;
        endcase
    end

    always_comb begin
        o_mode  = i_mode;
        o_timer = i_timer;
        case (i_mode)
            MODE_READY: begin
                case (cmd)
                    CMD_BUCKLE: begin
                        o_mode  = MODE_SLACK;
                        o_timer = '0;
                    end
                    CMD_UNBUCKLE: begin
                        o_mode  = MODE_PARKING;
                        o_timer = '0;
                    end
                    CMD_ALERT: begin
                        o_mode  = MODE_WARNING;
                        o_timer = '0;
                    end
                    CMD_TIGHTEN: begin
                        o_mode  = MODE_PRETENSION;
                        o_timer = '0;
                    end
                    default: begin
                    end
                endcase
            end
            MODE_FREEING: begin
                if (freeing_over) begin
                    o_mode  = MODE_READY;
                    o_timer = '0;
                end else begin
                    o_timer = timer_adv;
                end
            end
            MODE_RELEASING: begin
                if (releasing_over) begin
                    o_mode  = MODE_READY;
                    o_timer = '0;
                end else begin
                    o_timer = timer_adv;
                end
            end
            MODE_PARKING: begin
                if (i_belt_tension > i_cfg.parking_done_tension) begin
                    o_mode  = MODE_FREEING;
                    o_timer = '0;
                end
            end
            MODE_SLACK: begin
                if (i_belt_tension > i_cfg.slack_done_tension) begin
                    o_mode  = MODE_FREEING;
                    o_timer = '0;
                end
            end
            MODE_WARNING: begin
                if (warning_over) begin
                    o_mode  = MODE_FREEING;
                    o_timer = '0;
                end else begin
                    o_timer = timer_adv;
                end
            end
            MODE_PRETENSION: begin
                case (cmd)
                    CMD_RELEASE: begin
                        o_mode  = MODE_RELEASING;
                        o_timer = '0;
                    end
                    CMD_FREE: begin
                        o_mode  = MODE_FREEING;
                        o_timer = '0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/belt_tension_mode_controller.sv @@
// Belt tension mode controller: one transaction per cycle, one result each. Every input
// transaction is one control-period tick carrying a command and a measured belt tension;
// its result carries the tension reference of the mode that was in force before the tick
// and the mode after it. The tick is evaluated in the cycle it is accepted, the mode and
// timer registers update on that edge, and the result appears from the output register
// on the next cycle, so a new transaction can be taken every cycle. The single mode/timer
// feedback loop through btmc_step sets that rate. The output register only stalls intake
// when it is full and not being taken. Configuration writes are registered and must be
// made while no transaction is in flight.
// Depends on btmc_pkg, btmc_cfg_regs, btmc_step and the assertion macro header.
`timescale 1ns / 1ps
`include "belt_tension_mode_controller_macros.svh"

module belt_tension_mode_controller
    import btmc_pkg::*;
#(
    parameter int TIMER_BITS = 15
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    // Input channel.
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_command,
    input  logic signed [TENSION_W-1:0]  i_belt_tension,
    // Output channel.
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [TENSION_W-1:0]  o_tension_ref,
    output logic [2:0]                   o_mode
);

    t_cfg                        cfg;
    t_mode                       r_mode;
    t_mode                       n_mode;
    logic [TIMER_BITS-1:0]       r_timer;
    logic [TIMER_BITS-1:0]       n_timer;
    logic signed [TENSION_W-1:0] step_ref;
    logic                        r_out_valid;
    logic signed [TENSION_W-1:0] r_tension_ref;
    t_mode                       r_out_mode;
    logic                        in_accept;

    btmc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    btmc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_mode         (r_mode),
        .i_timer        (r_timer),
        .i_command      (i_command),
        .i_belt_tension (i_belt_tension),
        .i_cfg          (cfg),
        .o_tension_ref  (step_ref),
        .o_mode         (n_mode),
        .o_timer        (n_timer)
    );

    // Intake is open whenever the output register is empty or is draining this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // Mode and timer move only on an accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_READY;
            r_timer <= '0;
        end else if (in_accept) begin
            r_mode  <= n_mode;
            r_timer <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_tension_ref <= step_ref;
            r_out_mode    <= n_mode;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tension_ref = r_tension_ref;
    assign o_mode        = 3'(r_out_mode);

    // Modes without a running timer always hold it at zero.
    `BTMC_ASSERT_NOW(a_untimed_timer_zero, i_clk, i_rst_n,
        (r_mode == MODE_READY || r_mode == MODE_PARKING || r_mode == MODE_SLACK ||
         r_mode == MODE_PRETENSION), (r_timer == '0), "timer nonzero in an untimed mode")

    // A pending result always reports the current mode.
    `BTMC_ASSERT_NOW(a_out_mode_matches, i_clk, i_rst_n,
        r_out_valid, (r_out_mode == r_mode), "pending result disagrees with mode register")

    // Every accepted tick leaves a result in the output register.
    `BTMC_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n,
        (i_rst_n && in_accept), r_out_valid, "accepted tick produced no result")

    // Without an accepted tick the mode does not move.
    `BTMC_ASSERT_NEXT(a_mode_holds_idle, i_clk, i_rst_n,
        (i_rst_n && !in_accept), ($stable(r_mode) && $stable(r_timer)),
        "mode or timer changed without an accepted tick")

endmodule

@@ tb/tension_mode_checker.sv @@
// Checker for the belt tension mode controller: watches the configuration port and both
// channels, predicts each tick's result and compares it with what the block returns.
// Depends on btmc_pkg for the mode, command and register index codes.
`timescale 1ns / 1ps

module tension_mode_checker
    import btmc_pkg::*;
#(
    parameter int TIMER_BITS = 15
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [2:0]                   i_command,
    input  logic signed [TENSION_W-1:0]  i_belt_tension,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic signed [TENSION_W-1:0]  i_tension_ref,
    input  logic [2:0]                   i_mode,
    output int                           o_fail_count,
    output int                           o_pending
);

    localparam longint unsigned TIMER_MAX = (longint'(1) << TIMER_BITS) - 1;

    typedef struct packed {
        logic signed [TENSION_W-1:0] tension_ref;
        logic [2:0]                  mode;
    } t_tick_outcome;

    t_cfg            cfg_shadow;
    t_mode           mode_now;
    longint unsigned timer_now;
    t_tick_outcome   tick_outcomes[$];
    int              fail_total = 0;

    // Reference of a mode, picked out of the two packed tables.
    function automatic logic signed [TENSION_W-1:0] mode_reference(input t_mode m);
        case (m)
            MODE_READY, MODE_FREEING, MODE_RELEASING, MODE_PARKING:
                return cfg_shadow.ref_table_low[16*m +: 16];
            MODE_SLACK, MODE_WARNING, MODE_PRETENSION:
                return cfg_shadow.ref_table_high[16*(m - MODE_SLACK) +: 16];
            default:
                return '0;
        endcase
    endfunction

    task automatic enter_mode(input t_mode m);
        mode_now  = m;
        timer_now = 0;
    endtask

    // A timed mode leaves once the timer has passed its limit, else the timer grows
    // by the period step and saturates.
    task automatic run_timer(input longint unsigned limit, input t_mode next_mode);
        if (timer_now > limit) begin
            enter_mode(next_mode);
        end else begin
            timer_now = timer_now + cfg_shadow.period_step;
            if (timer_now > TIMER_MAX) begin
                timer_now = TIMER_MAX;
            end
        end
    endtask

    task automatic predict_tick(input t_command cmd, input logic signed [TENSION_W-1:0] tension,
                                output t_tick_outcome outcome);
        outcome.tension_ref = mode_reference(mode_now);
        case (mode_now)
            MODE_READY: begin
                case (cmd)
                    CMD_BUCKLE:   enter_mode(MODE_SLACK);
                    CMD_UNBUCKLE: enter_mode(MODE_PARKING);
                    CMD_ALERT:    enter_mode(MODE_WARNING);
                    CMD_TIGHTEN:  enter_mode(MODE_PRETENSION);
                    default: ;
                endcase
            end
            MODE_FREEING:   run_timer(cfg_shadow.freeing_limit, MODE_READY);
            MODE_RELEASING: run_timer(cfg_shadow.releasing_limit, MODE_READY);
            MODE_WARNING:   run_timer(cfg_shadow.warning_limit, MODE_FREEING);
            MODE_PARKING: begin
                if ($signed(tension) > $signed(cfg_shadow.parking_done_tension)) begin
                    enter_mode(MODE_FREEING);
                end
            end
            MODE_SLACK: begin
                if ($signed(tension) > $signed(cfg_shadow.slack_done_tension)) begin
                    enter_mode(MODE_FREEING);
                end
            end
            MODE_PRETENSION: begin
                if (cmd == CMD_RELEASE) begin
                    enter_mode(MODE_RELEASING);
                end else if (cmd == CMD_FREE) begin
                    enter_mode(MODE_FREEING);
                end
            end
            default: ;
        endcase
        outcome.mode = mode_now;
    endtask

    always @(posedge i_clk) begin
        t_tick_outcome fresh;
        t_tick_outcome oldest;
        if (!i_rst_n) begin
            cfg_shadow             = '0;
            cfg_shadow.period_step = STEP_RESET;
            mode_now               = MODE_READY;
            timer_now              = 0;
            tick_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_REF_TABLE_LOW:   cfg_shadow.ref_table_low        = i_cfg_data;
                    CFG_REF_TABLE_HIGH:  cfg_shadow.ref_table_high       = i_cfg_data[47:0];
                    CFG_PARKING_DONE:    cfg_shadow.parking_done_tension = i_cfg_data[15:0];
                    CFG_SLACK_DONE:      cfg_shadow.slack_done_tension   = i_cfg_data[15:0];
                    CFG_FREEING_LIMIT:   cfg_shadow.freeing_limit   = i_cfg_data[LIMIT_W-1:0];
                    CFG_RELEASING_LIMIT: cfg_shadow.releasing_limit = i_cfg_data[LIMIT_W-1:0];
                    CFG_WARNING_LIMIT:   cfg_shadow.warning_limit   = i_cfg_data[LIMIT_W-1:0];
                    CFG_PERIOD_STEP:     cfg_shadow.period_step     = i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            // A result leaves no earlier than the cycle after its tick, so the result
            // side is settled before this edge's tick is queued.
            if (i_out_valid && i_out_ready) begin
                if (tick_outcomes.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("unexpected result: tension_ref %0d mode %0d",
                                 i_tension_ref, i_mode);
                    end
                end else begin
                    oldest = tick_outcomes.pop_front();
                    if (i_tension_ref !== oldest.tension_ref || i_mode !== oldest.mode) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("mismatch: tension_ref exp %0d got %0d, mode exp %0d got %0d",
                                     oldest.tension_ref, i_tension_ref, oldest.mode, i_mode);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_tick(t_command'(i_command), i_belt_tension, fresh);
                tick_outcomes.push_back(fresh);
            end
        end
        o_pending    <= tick_outcomes.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ tb/testbench.sv @@
// Top of the belt tension mode controller testbench: clock, reset, configuration phases,
// tick stimulus with random idling on both channels, and the final verdict.
// Depends on btmc_pkg, the block itself and tension_mode_checker.
`timescale 1ns / 1ps

module testbench;
    import btmc_pkg::*;

    localparam int TIMER_BITS      = 15;
    // Each tick can wait up to the largest idle gap on each side; the cycle limit covers
    // the whole run many times over, the long receiver hold included.
    localparam int CYCLE_LIMIT     = 500000;
    localparam int NUM_PHASES      = 8;
    localparam int TICKS_PER_PHASE = 235;
    localparam int LONG_HOLD       = 300;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0]      i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data     = '0;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_ready;
    logic [2:0]                  i_command      = '0;
    logic signed [TENSION_W-1:0] i_belt_tension = '0;
    logic                        o_out_valid;
    logic                        i_out_ready    = 1'b0;
    logic signed [TENSION_W-1:0] o_tension_ref;
    logic [2:0]                  o_mode;

    int   fail_count;
    int   pending_count;
    int   cycle_count     = 0;
    // Largest idle gap each side may draw per transaction; zero gives back-to-back traffic.
    int   tx_gap_max      = 15;
    int   rx_gap_max      = 15;
    // A nonzero value asks the receiver to hold ready low for that many cycles.
    int   rx_hold_request = 0;
    t_cfg active_cfg;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    belt_tension_mode_controller #(
        .TIMER_BITS(TIMER_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_belt_tension (i_belt_tension),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_tension_ref  (o_tension_ref),
        .o_mode         (o_mode)
    );

    tension_mode_checker #(
        .TIMER_BITS(TIMER_BITS)
    ) monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_belt_tension (i_belt_tension),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_tension_ref  (o_tension_ref),
        .i_mode         (o_mode),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side. Ready is lowered for a random number of cycles before each result and
    // then held high until a result is taken. A pending long hold request replaces the
    // random gap once; the cycles are counted here so the sender keeps running meanwhile.
    initial begin : result_sink
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_request > 0) begin
                gap             = rx_hold_request;
                rx_hold_request = 0;
            end else begin
                gap = $urandom_range(0, rx_gap_max);
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Offers one tick. Valid is only dropped when a gap is drawn, so back-to-back ticks
    // keep it high without a low pulse inside one time step.
    task automatic offer_tick(input t_command cmd, input logic signed [TENSION_W-1:0] tension);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_belt_tension <= tension;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stops offering and waits until every predicted result has come back. The count the
    // checker reports is registered, so it is read only after a first edge, and a final
    // pause follows once it reads zero.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Writes all eight registers back to back while the block is idle. Bits above a
    // register's width carry random filler, which the block must ignore.
    task automatic program_settings(input t_cfg s);
        t_cfg_index reg_sel;
        reg_sel = reg_sel.first();
        repeat (reg_sel.num()) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= reg_sel;
            case (reg_sel)
                CFG_REF_TABLE_LOW:   i_cfg_data <= s.ref_table_low;
                CFG_REF_TABLE_HIGH:  i_cfg_data <= {16'($urandom), s.ref_table_high};
                CFG_PARKING_DONE:    i_cfg_data <= {48'($urandom), s.parking_done_tension};
                CFG_SLACK_DONE:      i_cfg_data <= {48'($urandom), s.slack_done_tension};
                CFG_FREEING_LIMIT:   i_cfg_data <= {49'($urandom), s.freeing_limit};
                CFG_RELEASING_LIMIT: i_cfg_data <= {49'($urandom), s.releasing_limit};
                CFG_WARNING_LIMIT:   i_cfg_data <= {49'($urandom), s.warning_limit};
                CFG_PERIOD_STEP:     i_cfg_data <= {54'($urandom), s.period_step};
                default:             i_cfg_data <= '0;
            endcase
            @(posedge i_clk);
            reg_sel = reg_sel.next();
        end
        i_cfg_we <= 1'b0;
    endtask

    // Tensions cluster on the full-scale ends and on either side of the active
    // completion thresholds, where parking and slack removing decide.
    function automatic logic signed [TENSION_W-1:0] pick_tension();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return $urandom_range(0, 1) ? active_cfg.parking_done_tension
                                                 : active_cfg.slack_done_tension;
            3:       return ($urandom_range(0, 1) ? active_cfg.parking_done_tension
                                                  : active_cfg.slack_done_tension) + 16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int phase;
        int tick;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed settings: distinct references with both full-scale values, zero time
        // limits so every timed mode turns around in two ticks, and the parking threshold
        // at the bottom of the range.
        active_cfg.ref_table_low        = {16'h0400, 16'h0300, 16'h7FFF, 16'h8000};
        active_cfg.ref_table_high       = {16'hFFFF, 16'h0600, 16'h0500};
        active_cfg.parking_done_tension = 16'sh8000;
        active_cfg.slack_done_tension   = 16'sd100;
        active_cfg.freeing_limit        = '0;
        active_cfg.releasing_limit      = '0;
        active_cfg.warning_limit        = '0;
        active_cfg.period_step          = STEP_W'(1);
        program_settings(active_cfg);

        // Ready ignores the undefined command and the pretension-only commands.
        offer_tick(CMD_NONE, 16'sd0);
        offer_tick(CMD_INVALID, 16'sh7FFF);
        offer_tick(CMD_RELEASE, -16'sd1);
        offer_tick(CMD_FREE, 16'sd1);
        // Slack removing holds at the threshold and completes one above it.
        offer_tick(CMD_BUCKLE, 16'sd0);
        offer_tick(CMD_INVALID, 16'sd100);
        offer_tick(CMD_NONE, 16'sd101);
        repeat (2) offer_tick(CMD_ALERT, 16'sd0);
        // Parking cannot complete at the lowest tension, but does one step above.
        offer_tick(CMD_UNBUCKLE, 16'sd0);
        offer_tick(CMD_NONE, 16'sh8000);
        offer_tick(CMD_INVALID, 16'sh8001);
        repeat (2) offer_tick(CMD_INVALID, 16'sd0);
        // Warning times out into freeing, freeing times out into ready.
        offer_tick(CMD_ALERT, 16'sd0);
        repeat (4) offer_tick(CMD_NONE, 16'sd0);
        // Pretension ignores buckling, then leaves on releasing and on freeing.
        offer_tick(CMD_TIGHTEN, 16'sd0);
        offer_tick(CMD_BUCKLE, 16'sd0);
        offer_tick(CMD_RELEASE, 16'sd0);
        repeat (2) offer_tick(CMD_NONE, 16'sd0);
        offer_tick(CMD_TIGHTEN, 16'sd0);
        offer_tick(CMD_FREE, 16'sd0);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();

            active_cfg.ref_table_low        = {$urandom, $urandom};
            active_cfg.ref_table_high       = {16'($urandom), $urandom};
            active_cfg.parking_done_tension = 16'($urandom);
            active_cfg.slack_done_tension   = 16'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                active_cfg.freeing_limit   = 15'($urandom);
                active_cfg.releasing_limit = 15'($urandom);
                active_cfg.warning_limit   = 15'($urandom);
                active_cfg.period_step     = STEP_W'($urandom_range(1, 1000));
            end else begin
                active_cfg.freeing_limit   = 15'($urandom_range(0, 20));
                active_cfg.releasing_limit = 15'($urandom_range(0, 20));
                active_cfg.warning_limit   = 15'($urandom_range(0, 20));
                active_cfg.period_step     = STEP_W'($urandom_range(1, 4));
            end
            case (phase)
                0: begin
                    // Top of every range: the timer runs into saturation and the
                    // thresholds can never be passed.
                    active_cfg.ref_table_low        = 64'h7FFF_8000_7FFF_8000;
                    active_cfg.ref_table_high       = 48'h8000_7FFF_8000;
                    active_cfg.parking_done_tension = 16'sh7FFF;
                    active_cfg.slack_done_tension   = 16'sh7FFF;
                    active_cfg.freeing_limit        = '1;
                    active_cfg.releasing_limit      = '1;
                    active_cfg.warning_limit        = '1;
                    active_cfg.period_step          = STEP_W'(1000);
                end
                1: begin
                    // Bottom of every range: each timed mode leaves once its timer passes zero.
                    active_cfg.ref_table_low        = '0;
                    active_cfg.ref_table_high       = '0;
                    active_cfg.parking_done_tension = 16'sh8000;
                    active_cfg.slack_done_tension   = 16'sh8000;
                    active_cfg.freeing_limit        = '0;
                    active_cfg.releasing_limit      = '0;
                    active_cfg.warning_limit        = '0;
                    active_cfg.period_step          = STEP_W'(1);
                end
                3: begin
                    // A zero step freezes the timer in the timed modes.
                    active_cfg.period_step = '0;
                end
                default: ;
            endcase
            program_settings(active_cfg);

            tx_gap_max = 15;
            rx_gap_max = 15;
            case (phase)
                2: begin
                    // The receiver stalls for a long stretch while ticks keep coming,
                    // so the output register fills and intake backs up.
                    tx_gap_max      = 0;
                    rx_hold_request = LONG_HOLD;
                end
                5: begin
                    tx_gap_max = 0;
                    rx_gap_max = 0;
                end
                6: rx_gap_max = 0;
                7: tx_gap_max = 0;
                default: ;
            endcase

            for (tick = 0; tick < TICKS_PER_PHASE; tick++) begin
                // Halfway through one phase the sender waits for every result.
                if (phase == 4 && tick == TICKS_PER_PHASE / 2) begin
                    drain_results();
                end
                offer_tick(t_command'($urandom_range(CMD_NONE, CMD_INVALID)), pick_tension());
            end
        end

        drain_results();
        repeat (3) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
